@@ src/hotkey_remap_injector_macros.svh @@
// Assertion macros shared by the hotkey remap injector modules.
// Depends on a clock named clk and a synchronous reset named rst in scope.
`ifndef HOTKEY_REMAP_INJECTOR_MACROS_SVH
`define HOTKEY_REMAP_INJECTOR_MACROS_SVH

// Property checked at every clock edge outside reset.
`define HRI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define HRI_ASSERT_NEVER(label, cond, msg) \
  `HRI_ASSERT(label, !(cond), msg)

`endif

@@ src/hri_pkg.sv @@
// Shared types, key codes and the injected run table for the hotkey remap injector.
// No dependencies.
package hri_pkg;

  typedef logic [9:0] key_code_t;

  localparam logic [4:0] EVT_KEY = 5'd1;

  localparam logic [1:0] ST_RELEASE = 2'd0;
  localparam logic [1:0] ST_PRESS   = 2'd1;
  localparam logic [1:0] ST_HOLD    = 2'd2;

  localparam key_code_t CODE_LCTRL  = 10'd29;
  localparam key_code_t CODE_RCTRL  = 10'd97;
  localparam key_code_t CODE_LSHIFT = 10'd42;
  localparam key_code_t CODE_RSHIFT = 10'd54;
  localparam key_code_t CODE_TAB    = 10'd15;
  localparam key_code_t CODE_DEL    = 10'd111;
  localparam key_code_t CODE_PAUSE  = 10'd119;
  localparam key_code_t CODE_PGUP   = 10'd104;
  localparam key_code_t CODE_PGDN   = 10'd109;
  localparam key_code_t CODE_HOME   = 10'd102;
  localparam key_code_t CODE_END    = 10'd107;

  // Command queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef logic [2:0] step_t;
  localparam step_t SHORT_LAST = 3'd3;
  localparam step_t LONG_LAST  = 3'd5;

  typedef struct packed {
    logic      long_run;   // ctrl held: six-event run
    key_code_t target;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_slot_t;

  typedef struct packed {
    key_code_t code;
    logic      pressed;
    logic      last;
  } inj_t;

  function automatic inj_t run_event(cmd_t c, step_t step);
    inj_t r;
    r.code    = CODE_LSHIFT;
    r.pressed = 1'b0;
    r.last    = 1'b0;
    if (c.long_run) begin
      unique case (step)
        3'd0: begin r.code = CODE_LSHIFT; r.pressed = 1'b0; end
        3'd1: begin r.code = CODE_LCTRL;  r.pressed = 1'b0; end
        3'd2: begin r.code = c.target;    r.pressed = 1'b1; end
        3'd3: begin r.code = c.target;    r.pressed = 1'b0; end
        3'd4: begin r.code = CODE_LCTRL;  r.pressed = 1'b1; end
        LONG_LAST: begin
          r.code = CODE_LSHIFT; r.pressed = 1'b1; r.last = 1'b1;
        end
        default: begin r.code = CODE_LSHIFT; r.pressed = 1'b0; end
      endcase
    end else begin
      unique case (step)
        3'd0: begin r.code = CODE_LSHIFT; r.pressed = 1'b0; end
        3'd1: begin r.code = c.target;    r.pressed = 1'b1; end
        3'd2: begin r.code = c.target;    r.pressed = 1'b0; end
        SHORT_LAST: begin
          r.code = CODE_LSHIFT; r.pressed = 1'b1; r.last = 1'b1;
        end
        default: begin r.code = CODE_LSHIFT; r.pressed = 1'b0; end
      endcase
    end
    return r;
  endfunction

endpackage

@@ src/hri_front.sv @@
// Front end: takes key events, tracks modifier and enable flags, issues run commands.
// Depends on hri_pkg.
module hri_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [4:0]        event_type,
  input  logic [9:0]        key_code_in,
  input  logic [1:0]        key_state,
  input  logic              queue_full,
  output logic              full,
  output logic              cmd_push,
  output hri_pkg::cmd_t     cmd
);
  import hri_pkg::*;

  logic shift_held, ctrl_held, remap_enabled;
  logic shift_held_next, ctrl_held_next, remap_enabled_next;
  logic accept, is_key, is_shift, is_ctrl, active, tab_toggle, is_del, is_pause;

  assign full     = queue_full;
  assign accept   = push && !queue_full;
  assign is_key   = (event_type == EVT_KEY);
  assign is_shift = (key_code_in == CODE_LSHIFT) || (key_code_in == CODE_RSHIFT);
  assign is_ctrl  = (key_code_in == CODE_LCTRL) || (key_code_in == CODE_RCTRL);
  assign active   = (key_state == ST_PRESS) || (key_state == ST_HOLD);
  assign is_del   = (key_code_in == CODE_DEL);
  assign is_pause = (key_code_in == CODE_PAUSE);

  always_comb begin
    shift_held_next = shift_held;
    ctrl_held_next  = ctrl_held;
    if (is_key && is_shift && key_state == ST_PRESS)   shift_held_next = 1'b1;
    if (is_key && is_shift && key_state == ST_RELEASE) shift_held_next = 1'b0;
    if (is_key && is_ctrl && key_state == ST_PRESS)    ctrl_held_next  = 1'b1;
    if (is_key && is_ctrl && key_state == ST_RELEASE)  ctrl_held_next  = 1'b0;
  end

  assign tab_toggle = is_key && (key_code_in == CODE_TAB) && (key_state == ST_PRESS)
                      && ctrl_held_next && shift_held_next;
  assign remap_enabled_next = remap_enabled ^ tab_toggle;

  // Delete and Pause are never Tab, so the enable flag seen here is the current one
  assign cmd_push = accept && is_key && active && remap_enabled && shift_held_next
                    && (is_del || is_pause);

  always_comb begin
    cmd.long_run = ctrl_held_next;
    if (ctrl_held_next) begin
      cmd.target = is_del ? CODE_END : CODE_HOME;
    end else begin
      cmd.target = is_del ? CODE_PGUP : CODE_PGDN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_held    <= 1'b0;
      ctrl_held     <= 1'b0;
      remap_enabled <= 1'b1;
    end else if (accept) begin
      shift_held    <= shift_held_next;
      ctrl_held     <= ctrl_held_next;
      remap_enabled <= remap_enabled_next;
    end
  end

endmodule

@@ src/hri_cmd_fifo.sv @@
// Short command queue between the front end and the run sequencer.
// Depends on hri_pkg and hotkey_remap_injector_macros.svh.
`include "hotkey_remap_injector_macros.svh"

module hri_cmd_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  hri_pkg::cmd_t       wr_cmd,
  input  logic                rd_en,
  output logic                queue_full,
  output hri_pkg::cmd_slot_t  head
);
  import hri_pkg::*;

  cmd_t                 mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr, rd_ptr;
  logic [FIFO_CW-1:0]   count;
  logic                 do_wr, do_rd;

  assign queue_full = (count == FIFO_CW'(FIFO_DEPTH));
  assign do_wr      = wr_en && !queue_full;
  assign do_rd      = rd_en && (count != '0);
  assign head.valid = (count != '0);
  assign head.cmd   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      unique case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `HRI_ASSERT_NEVER(a_no_write_when_full, queue_full && wr_en, "command written to full queue")
  `HRI_ASSERT(a_ptr_count_agree, (wr_ptr - rd_ptr) == count[FIFO_AW-1:0], "pointers and count disagree")

endmodule

@@ src/hri_back.sv @@
// Back end: steps through each queued run and holds one injected event for transfer.
// Depends on hri_pkg and hotkey_remap_injector_macros.svh.
`include "hotkey_remap_injector_macros.svh"

module hri_back (
  input  logic                clk,
  input  logic                rst,
  input  hri_pkg::cmd_slot_t  head,
  output logic                take,
  input  logic                pop,
  output logic                empty,
  output logic [9:0]          out_key_code,
  output logic                out_key_state,
  output logic                last_of_run
);
  import hri_pkg::*;

  step_t step;
  logic  out_valid, load;
  inj_t  ev;

  assign empty = !out_valid;
  assign load  = !out_valid || pop;
  assign ev    = run_event(head.cmd, step);
  // queue entry is retired as its final event enters the output register
  assign take  = load && head.valid && ev.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step      <= '0;
    end else if (load) begin
      out_valid <= head.valid;
      if (head.valid) begin
        step <= ev.last ? '0 : step + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && head.valid) begin
      out_key_code  <= ev.code;
      out_key_state <= ev.pressed;
      last_of_run   <= ev.last;
    end
  end

  `HRI_ASSERT(a_step_needs_cmd, (step != '0) |-> head.valid, "mid-run with no queued command")
  `HRI_ASSERT(a_step_in_run, (step == '0) || (head.cmd.long_run ? (step <= LONG_LAST) : (step <= SHORT_LAST)), "run step past end")

endmodule

@@ src/hotkey_remap_injector.sv @@
// The first injected event reaches the result ports through the command queue and then the output register.
// One input per cycle is taken while the four-entry command queue has room; the back
// sequencer emits one event per cycle while pop keeps its output register free, and an
// injecting input yields a run of four or six events, all other inputs produce nothing.
// Reset: shift and ctrl flags cleared, remapping enabled, queue and output register empty.
module hotkey_remap_injector (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [4:0] event_type,
  input  logic [9:0] key_code_in,
  input  logic [1:0] key_state,
  output logic       empty,
  input  logic       pop,
  output logic [9:0] out_key_code,
  output logic       out_key_state,
  output logic       last_of_run
);
  import hri_pkg::*;

  logic      queue_full, cmd_push, take;
  cmd_t      cmd;
  cmd_slot_t head;

  hri_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .event_type  (event_type),
    .key_code_in (key_code_in),
    .key_state   (key_state),
    .queue_full  (queue_full),
    .full        (full),
    .cmd_push    (cmd_push),
    .cmd         (cmd)
  );

  hri_cmd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (cmd_push),
    .wr_cmd     (cmd),
    .rd_en      (take),
    .queue_full (queue_full),
    .head       (head)
  );

  hri_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .take          (take),
    .pop           (pop),
    .empty         (empty),
    .out_key_code  (out_key_code),
    .out_key_state (out_key_state),
    .last_of_run   (last_of_run)
  );

endmodule
